// ===== rtl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// Types, constants and helper functions shared by the 3x3 box blur modules.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int PIX_W = 24;
  localparam int CH_W = 8;
  localparam int SUM_W = 12;
  localparam int CNT_W = 4;
  localparam int SCALE_X_W = SUM_W + 1;
  localparam int RECIP_W = 18;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_W = SCALE_X_W + RECIP_W;

  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 1;
  localparam int FW_FIELD_W = 11;
  localparam int HEIGHT_W = 13;
  localparam int HEIGHT_MAX = 4096;
  localparam int HEIGHT_RESET = 1024;
  localparam int WIDTH_RESET = 1024;
  localparam int WIDTH_FIELD_MAX = 2047;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // One stored stream word together with how the back end must treat it.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             emit;
    logic             last;
    logic             top;
    logic             bottom;
    logic             left;
    logic             right;
  } bb3_op_t;

  // Scaled reciprocal of twice the neighbor count: ceil(2^18 / (2*n)).
  // Exact floor division for every dividend below 8192.
  function automatic logic [RECIP_W-1:0] bb3_recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 18'd131072;
      4'd2:    r = 18'd65536;
      4'd3:    r = 18'd43691;
      4'd4:    r = 18'd32768;
      4'd6:    r = 18'd21846;
      4'd9:    r = 18'd14564;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/box_blur_3x3_edge_average_top.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_average_top
// 3x3 box blur over an RGB raster stream with border-aware averaging.
// ----------------------------------------------------------------------------
// Send the W*H pixels of a frame in raster order, then W+1 more words (drain
// words, or pixels whose data is dropped) to flush the tail; output pixel q
// leaves after word q+W+1, and the word that ends the frame is marked with
// frame_last. Drain words sent while frame pixels are still due are dropped.
// Every other word passes a read state and a shift state in the back end, to
// read and then rewrite the line memories at its column; the back end takes
// no new word before it is through with the last, and a four-word queue lets
// the input run ahead of it. The line memories need no clearing pass after
// reset. A write to either register restarts the frame; the user must make it
// only while the block is idle, as the block itself does not enforce this.
module box_blur_3x3_edge_average_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [7:0]                    red_in,
  input  logic [7:0]                    green_in,
  input  logic [7:0]                    blue_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    red_out,
  output logic [7:0]                    green_out,
  output logic [7:0]                    blue_out,
  output logic                          frame_last
);
  import bb3_pkg::*;

  localparam int WIDTH_MAX_EFF = (MAX_WIDTH < WIDTH_FIELD_MAX) ? MAX_WIDTH : WIDTH_FIELD_MAX;
  localparam int COL_W = (WIDTH_MAX_EFF > 1) ? $clog2(WIDTH_MAX_EFF) : 1;

  logic             push;
  bb3_op_t          push_op;
  logic [COL_W-1:0] push_col;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  bb3_op_t          head_op;
  logic [COL_W-1:0] head_col;

  bb3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .push         (push),
    .push_op      (push_op),
    .push_col     (push_col),
    .q_full       (q_full)
  );

  bb3_queue #(
    .COL_W (COL_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .push_col   (push_col),
    .full       (q_full),
    .head_valid (q_valid),
    .pop        (pop),
    .head_op    (head_op),
    .head_col   (head_col)
  );

  bb3_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_op       (head_op),
    .q_col      (head_col),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .frame_last (frame_last)
  );

endmodule

// ===== rtl/bb3_front.sv =====
// ----------------------------------------------------------------------------
// bb3_front
// Accepts stream words, tracks input and output positions in the frame and
// tags each stored word with its emit flag, last flag and border flags.
// ----------------------------------------------------------------------------
module bb3_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [7:0]                  red_in,
  input  logic [7:0]                  green_in,
  input  logic [7:0]                  blue_in,
  output logic                        push,
  output bb3_pkg::bb3_op_t            push_op,
  output logic [((MAX_WIDTH < 2047 ? MAX_WIDTH : 2047) > 1 ?
                 $clog2(MAX_WIDTH < 2047 ? MAX_WIDTH : 2047) : 1)-1:0] push_col,
  input  logic                        q_full
);
  import bb3_pkg::*;

  localparam int WIDTH_MAX_EFF = (MAX_WIDTH < WIDTH_FIELD_MAX) ? MAX_WIDTH : WIDTH_FIELD_MAX;
  localparam int COL_W = (WIDTH_MAX_EFF > 1) ? $clog2(WIDTH_MAX_EFF) : 1;
  localparam int WREG_W = $clog2(WIDTH_MAX_EFF + 1);
  localparam int WIDTH_RESET_EFF = (WIDTH_MAX_EFF < WIDTH_RESET) ? WIDTH_MAX_EFF : WIDTH_RESET;

  logic [WREG_W-1:0]   width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic [HEIGHT_W-1:0] in_row;
  logic [COL_W-1:0]    in_col;
  logic [HEIGHT_W-2:0] out_row;
  logic [COL_W-1:0]    out_col;

  logic [WREG_W-1:0]     width_m1;
  logic [HEIGHT_W-1:0]   height_m1;
  logic [FW_FIELD_W-1:0] fw;
  logic [HEIGHT_W-1:0]   fh;
  logic [WREG_W-1:0]     width_next;
  logic [HEIGHT_W-1:0]   height_next;
  logic                  accept;
  logic                  tail;
  logic                  ignore;
  logic                  emit;
  logic                  in_col_end;
  logic                  out_col_end;
  logic                  out_row_end;
  logic                  last;

  always_comb begin
    fw = cfg_data[FW_FIELD_W-1:0];
    fh = cfg_data[HEIGHT_W-1:0];
    if (fw == '0) begin
      width_next = WREG_W'(1);
    end else if (int'(fw) > WIDTH_MAX_EFF) begin
      width_next = WREG_W'(WIDTH_MAX_EFF);
    end else begin
      width_next = WREG_W'(fw);
    end
    if (fh == '0) begin
      height_next = HEIGHT_W'(1);
    end else if (int'(fh) > HEIGHT_MAX) begin
      height_next = HEIGHT_W'(HEIGHT_MAX);
    end else begin
      height_next = fh;
    end
  end

  always_comb begin
    width_m1 = width_eff - WREG_W'(1);
    height_m1 = height_eff - HEIGHT_W'(1);
    in_ready = !q_full;
    accept = in_valid && in_ready;
    // Once every pixel of the frame is in, all words only push the tail out.
    tail = (in_row >= height_eff);
    ignore = !tail && mode;
    push = accept && !ignore;
    emit = (in_row > HEIGHT_W'(1)) || ((in_row == HEIGHT_W'(1)) && (in_col != '0));
    in_col_end = (WREG_W'(in_col) == width_m1);
    out_col_end = (WREG_W'(out_col) == width_m1);
    out_row_end = ({1'b0, out_row} == height_m1);
    last = out_row_end && out_col_end;

    push_op.pixel = tail ? '0 : {blue_in, green_in, red_in};
    push_op.emit = emit;
    push_op.last = last;
    push_op.top = (out_row == '0);
    push_op.bottom = out_row_end;
    push_op.left = (out_col == '0);
    push_op.right = out_col_end;
    push_col = in_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff <= WREG_W'(WIDTH_RESET_EFF);
      height_eff <= HEIGHT_W'(HEIGHT_RESET);
      in_row <= '0;
      in_col <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  width_eff <= width_next;
        REG_FRAME_HEIGHT: height_eff <= height_next;
        default: ;
      endcase
      in_row <= '0;
      in_col <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (push) begin
      if (in_col_end) begin
        in_col <= '0;
        in_row <= in_row + HEIGHT_W'(1);
      end else begin
        in_col <= in_col + COL_W'(1);
      end
      if (emit) begin
        if (last) begin
          in_row <= '0;
          in_col <= '0;
          out_row <= '0;
          out_col <= '0;
        end else if (out_col_end) begin
          out_col <= '0;
          out_row <= out_row + (HEIGHT_W - 1)'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/bb3_queue.sv =====
// ----------------------------------------------------------------------------
// bb3_queue
// Short first-in first-out queue of tagged words between front and back end.
// ----------------------------------------------------------------------------
module bb3_queue #(
  parameter int COL_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bb3_pkg::bb3_op_t push_op,
  input  logic [COL_W-1:0] push_col,
  output logic             full,
  output logic             head_valid,
  input  logic             pop,
  output bb3_pkg::bb3_op_t head_op,
  output logic [COL_W-1:0] head_col
);
  import bb3_pkg::*;

  bb3_op_t          op_store [QUEUE_DEPTH];
  logic [COL_W-1:0] col_store [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op = op_store[rd_ptr];
  assign head_col = col_store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_store[wr_ptr] <= push_op;
      col_store[wr_ptr] <= push_col;
    end
  end

endmodule

// ===== rtl/bb3_back.sv =====
// ----------------------------------------------------------------------------
// bb3_back
// Line memories, 3x3 window, masked channel sums and the divide by the
// neighbor count, ending in the output register.
// ----------------------------------------------------------------------------
module bb3_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  bb3_pkg::bb3_op_t q_op,
  input  logic [((MAX_WIDTH < 2047 ? MAX_WIDTH : 2047) > 1 ?
                 $clog2(MAX_WIDTH < 2047 ? MAX_WIDTH : 2047) : 1)-1:0] q_col,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       red_out,
  output logic [7:0]       green_out,
  output logic [7:0]       blue_out,
  output logic             frame_last
);
  import bb3_pkg::*;

  localparam int WIDTH_MAX_EFF = (MAX_WIDTH < WIDTH_FIELD_MAX) ? MAX_WIDTH : WIDTH_FIELD_MAX;
  localparam int COL_W = (WIDTH_MAX_EFF > 1) ? $clog2(WIDTH_MAX_EFF) : 1;

  localparam logic S_READ = 1'b0;
  localparam logic S_SHIFT = 1'b1;

  logic [PIX_W-1:0] upper_line [WIDTH_MAX_EFF];
  logic [PIX_W-1:0] middle_line [WIDTH_MAX_EFF];
  logic [PIX_W-1:0] up_rd;
  logic [PIX_W-1:0] mid_rd;

  logic             state;
  bb3_op_t          op;
  logic [COL_W-1:0] col;
  logic [PIX_W-1:0] win [3][3];

  logic             sum_valid;
  logic [SUM_W-1:0] sums [3];
  logic [CNT_W-1:0] cnt;
  logic             sum_last;

  logic             shift_go;
  logic             sum_take;
  logic [PIX_W-1:0] new_col [3];
  logic [2:0]       row_ok;
  logic [2:0]       col_ok;
  logic [1:0]       row_cnt;
  logic [1:0]       col_cnt;
  logic [SUM_W-1:0] sum_next [3];
  logic [CNT_W-1:0] cnt_next;
  logic [CH_W-1:0]  scaled [3];

  always_comb begin
    pop = (state == S_READ) && q_valid;
    sum_take = sum_valid && (!out_valid || out_ready);
    shift_go = (state == S_SHIFT) && (!op.emit || !sum_valid || sum_take);
  end

  // The new right column: rows two above, one above and the current row.
  always_comb begin
    new_col[0] = up_rd;
    new_col[1] = mid_rd;
    new_col[2] = op.pixel;
    row_ok = {!op.bottom, 1'b1, !op.top};
    col_ok = {!op.right, 1'b1, !op.left};
    row_cnt = 2'd1 + 2'(!op.top) + 2'(!op.bottom);
    col_cnt = 2'd1 + 2'(!op.left) + 2'(!op.right);
    cnt_next = CNT_W'(row_cnt) * CNT_W'(col_cnt);
    for (int ch = 0; ch < 3; ch++) begin
      sum_next[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (row_ok[r] && col_ok[c]) begin
            if (c == 2) begin
              sum_next[ch] = sum_next[ch] + SUM_W'(new_col[r][ch*CH_W +: CH_W]);
            end else begin
              sum_next[ch] = sum_next[ch] + SUM_W'(win[r][c+1][ch*CH_W +: CH_W]);
            end
          end
        end
      end
    end
  end

  // Round half up: (2*sum + n) / (2*n), done as a reciprocal multiply.
  always_comb begin
    logic [SCALE_X_W-1:0] x;
    logic [PROD_W-1:0]    prod;
    for (int ch = 0; ch < 3; ch++) begin
      x = {sums[ch], 1'b0} + SCALE_X_W'(cnt);
      prod = PROD_W'(x) * PROD_W'(bb3_recip(cnt));
      scaled[ch] = prod[RECIP_SHIFT +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      up_rd <= upper_line[q_col];
      mid_rd <= middle_line[q_col];
    end
    if (shift_go) begin
      upper_line[col] <= mid_rd;
      middle_line[col] <= op.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_READ;
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_READ:  if (q_valid) state <= S_SHIFT;
        S_SHIFT: if (shift_go) state <= S_READ;
        default: state <= S_READ;
      endcase
      if (shift_go && op.emit) begin
        sum_valid <= 1'b1;
      end else if (sum_take) begin
        sum_valid <= 1'b0;
      end
      if (sum_take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op <= q_op;
      col <= q_col;
    end
    if (shift_go) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
        win[r][2] <= new_col[r];
      end
      if (op.emit) begin
        sums <= sum_next;
        cnt <= cnt_next;
        sum_last <= op.last;
      end
    end
    if (sum_take) begin
      red_out <= scaled[0];
      green_out <= scaled[1];
      blue_out <= scaled[2];
      frame_last <= sum_last;
    end
  end

endmodule

// ===== rtl/bb3_checker.sv =====
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks for the box blur top level, attached by bind.
// ----------------------------------------------------------------------------
module bb3_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic       frame_last
);

  // Accepted input words not yet matched by a delivered word; sticks at full.
  logic [15:0] credit;
  logic        in_acc;
  logic        out_acc;

  assign in_acc = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else if (credit != 16'hFFFF) begin
      credit <= 16'(credit + 16'(in_acc) - 16'(out_acc));
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
      && $stable(blue_out) && $stable(frame_last))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> credit != 16'd0)
    else $error("output word with no input word behind it");

  a_accept_moves_credit: assert property (@(posedge clk) disable iff (rst)
    in_acc && !out_acc && credit != 16'hFFFF |=> credit != 16'd0)
    else $error("accepted input word lost from the count");

endmodule

bind box_blur_3x3_edge_average_top bb3_checker u_bb3_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .red_out    (red_out),
  .green_out  (green_out),
  .blue_out   (blue_out),
  .frame_last (frame_last)
);
